[design/lxm_pkg.sv]
// ----------------------------------------------------------------------------
// LXM generator package
// Shared widths, codes, reset values and helper functions for the L64X1024Mix
// random number generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lxm_pkg;

   // Field and word widths.
   localparam int WORD_W      = 64;
   localparam int HALF_W      = 32;
   localparam int MODE_W      = 2;
   localparam int INDEX_W     = 4;
   localparam int CSR_INDEX_W = 1;

   // Ring size and the depth of the queue between front and back.
   localparam int RING_DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;

   // Item modes as they arrive on the request channel.
   localparam logic [MODE_W-1:0] MODE_GENERATE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_RING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD_LCG  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LCG_INCREMENT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LCG_MULTIPLIER = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [WORD_W-1:0] LCG_INCREMENT_RESET  = 64'd1;
   localparam logic [WORD_W-1:0] LCG_MULTIPLIER_RESET = 64'hd134_2543_de82_ef95;

   // Multiplier of the 64-bit mixing function.
   localparam logic [WORD_W-1:0] LEA_MULT = 64'hdaba_0b6e_b093_22e3;

   // Fixed rotate and shift amounts of the xoroshiro1024 update.
   localparam int ROT_S0  = 25;
   localparam int SHL_T   = 27;
   localparam int ROT_T   = 36;

   // Operation held in the queue once an item has been classified.
   typedef enum logic [1:0] {
      OP_GENERATE,
      OP_LOAD_RING,
      OP_LOAD_LCG
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  word_index;
      logic [WORD_W-1:0]   load_value;
   } item_type;

   // Status of the back end as seen by the top level.
   typedef struct packed {
      logic busy;
      logic publish;
   } back_status_type;

   // Rotate left by a constant amount.
   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amt);
      rotl = (v << amt) | (v >> (WORD_W - amt));
   endfunction

   // Fold the upper half into the lower half, as the mix does between products.
   function automatic logic [WORD_W-1:0] fold(input logic [WORD_W-1:0] z);
      fold = z ^ (z >> HALF_W);
   endfunction

endpackage

`default_nettype wire

[design/lxm_ram.sv]
// ----------------------------------------------------------------------------
// LXM generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lxm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/lxm_front.sv]
// ----------------------------------------------------------------------------
// LXM front end
// Accepts request beats, classifies the mode and queues the resulting work
// for the back end. The unused mode is accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lxm_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lxm_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [lxm_pkg::INDEX_W-1:0]   req_word_index,
   input  wire logic [lxm_pkg::WORD_W-1:0]    req_load_value,
   output logic                               q_valid,
   output lxm_pkg::item_type                  q_item,
   input  wire logic                          q_pop
);

   localparam int PtrW   = $clog2(lxm_pkg::QUEUE_DEPTH);
   localparam int CountW = $clog2(lxm_pkg::QUEUE_DEPTH + 1);

   lxm_pkg::item_type  entry_ff [lxm_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;

   lxm_pkg::item_type  item;
   logic               keep;
   logic               push;
   logic               pop;

   // Classify the incoming beat; the unused mode is not queued.
   always_comb begin
      item.word_index = req_word_index;
      item.load_value = req_load_value;
      item.op         = lxm_pkg::OP_GENERATE;
      keep            = 1'b1;
      case (req_mode)
         lxm_pkg::MODE_GENERATE:  item.op = lxm_pkg::OP_GENERATE;
         lxm_pkg::MODE_LOAD_RING: item.op = lxm_pkg::OP_LOAD_RING;
         lxm_pkg::MODE_LOAD_LCG:  item.op = lxm_pkg::OP_LOAD_LCG;
         default:                 keep    = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != CountW'(lxm_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready && keep;
   assign pop       = q_pop && q_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(lxm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(lxm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[design/lxm_back.sv]
// ----------------------------------------------------------------------------
// LXM back end
// Carries out queued items: ring and LCG loads, and the generate sequence of
// ring reads, ring updates and three 64-bit products on a shared 32x32
// multiplier. Holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lxm_back #(
   parameter int RING_DEPTH = lxm_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire lxm_pkg::item_type             q_item,
   output logic                               q_pop,
   input  wire logic [lxm_pkg::WORD_W-1:0]    lcg_increment,
   input  wire logic [lxm_pkg::WORD_W-1:0]    lcg_multiplier,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lxm_pkg::WORD_W-1:0]    rsp_random_value,
   output lxm_pkg::back_status_type           status
);

   localparam int RingAw = $clog2(RING_DEPTH);
   localparam int W      = lxm_pkg::WORD_W;
   localparam int H      = lxm_pkg::HALF_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_S0,
      ST_READ_S15,
      ST_WRITE_NP,
      ST_MULTIPLY,
      ST_PUBLISH
   } state_type;

   typedef enum logic [1:0] {
      PASS_MIX1,
      PASS_MIX2,
      PASS_LCG
   } pass_type;

   state_type           state_ff;
   pass_type            pass_ff;
   logic [1:0]          step_ff;
   logic [RingAw-1:0]   ptr_ff;
   logic [RING_DEPTH-1:0] valid_ff;
   logic                rd_ok_ff;
   logic [W-1:0]        lcg_ff;
   logic [W-1:0]        s0_ff;
   logic [W-1:0]        t_ff;
   logic [W-1:0]        a_ff;
   logic [W-1:0]        b_ff;
   logic [W-1:0]        prod_ff;
   logic [W-1:0]        acc_ff;
   logic [W-1:0]        mix_ff;
   logic                rsp_valid_ff;
   logic [W-1:0]        rsp_value_ff;

   logic [RingAw-1:0]   next_ptr;
   logic [RingAw-1:0]   rd_addr;
   logic [W-1:0]        rd_data;
   logic [W-1:0]        word;
   logic [W-1:0]        t_now;
   logic                wr_en;
   logic [RingAw-1:0]   wr_addr;
   logic [W-1:0]        wr_data;
   logic [H-1:0]        mul_x;
   logic [H-1:0]        mul_y;
   logic [W-1:0]        product_sum;
   logic                slot_free;
   logic                publish;

   assign next_ptr  = ptr_ff + 1'b1;
   assign word      = rd_ok_ff ? rd_data : '0;
   assign t_now     = s0_ff ^ word;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign publish   = (state_ff == ST_PUBLISH) && slot_free;

   // Ring read address: the new word first, then the word under the pointer.
   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = next_ptr;
         default: rd_addr = ptr_ff;
      endcase
   end

   // Ring write port: loads, then the two xoroshiro1024 updates.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_item.op == lxm_pkg::OP_LOAD_RING) begin
               wr_en   = 1'b1;
               wr_addr = RingAw'(q_item.word_index);
               wr_data = q_item.load_value;
            end
         end
         ST_READ_S15: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = lxm_pkg::rotl(s0_ff, lxm_pkg::ROT_S0) ^ t_now
                      ^ (t_now << lxm_pkg::SHL_T);
         end
         ST_WRITE_NP: begin
            wr_en   = 1'b1;
            wr_addr = next_ptr;
            wr_data = lxm_pkg::rotl(t_ff, lxm_pkg::ROT_T);
         end
         default: wr_en = 1'b0;
      endcase
   end

   lxm_ram #(
      .WIDTH (W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Partial product operands: low x low, low x high, high x low.
   always_comb begin
      case (step_ff)
         2'd0:    begin mul_x = a_ff[H-1:0]; mul_y = b_ff[H-1:0]; end
         2'd1:    begin mul_x = a_ff[H-1:0]; mul_y = b_ff[W-1:H]; end
         default: begin mul_x = a_ff[W-1:H]; mul_y = b_ff[H-1:0]; end
      endcase
   end

   // Low 64 bits of the full product once the last cross term has arrived.
   assign product_sum = acc_ff + {prod_ff[H-1:0], {H{1'b0}}};

   // Sequencer, datapath registers and response register.
   always_ff @(posedge clock) begin
      rd_ok_ff <= valid_ff[rd_addr];
      prod_ff  <= W'(mul_x) * W'(mul_y);

      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_MIX1;
         step_ff      <= '0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         lcg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         // The response drops once taken, unless a new one is loaded in its place.
         if (rsp_valid_ff && rsp_ready && !publish) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  case (q_item.op)
                     lxm_pkg::OP_GENERATE:  state_ff <= ST_READ_S0;
                     lxm_pkg::OP_LOAD_LCG:  lcg_ff   <= q_item.load_value;
                     default:               state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_READ_S0: begin
               s0_ff    <= word;
               state_ff <= ST_READ_S15;
            end
            ST_READ_S15: begin
               t_ff     <= t_now;
               a_ff     <= lxm_pkg::fold(lcg_ff + s0_ff);
               b_ff     <= lxm_pkg::LEA_MULT;
               pass_ff  <= PASS_MIX1;
               state_ff <= ST_WRITE_NP;
            end
            ST_WRITE_NP: begin
               ptr_ff   <= next_ptr;
               step_ff  <= '0;
               state_ff <= ST_MULTIPLY;
            end
            ST_MULTIPLY: begin
               step_ff <= step_ff + 1'b1;
               case (step_ff)
                  2'd0: acc_ff <= acc_ff;
                  2'd1: acc_ff <= prod_ff;
                  2'd2: acc_ff <= product_sum;
                  default: begin
                     case (pass_ff)
                        PASS_MIX1: begin
                           a_ff    <= lxm_pkg::fold(product_sum);
                           b_ff    <= lxm_pkg::LEA_MULT;
                           pass_ff <= PASS_MIX2;
                        end
                        PASS_MIX2: begin
                           mix_ff  <= lxm_pkg::fold(product_sum);
                           a_ff    <= lcg_ff;
                           b_ff    <= lcg_multiplier;
                           pass_ff <= PASS_LCG;
                        end
                        default: begin
                           acc_ff   <= product_sum;
                           state_ff <= ST_PUBLISH;
                        end
                     endcase
                  end
               endcase
            end
            ST_PUBLISH: begin
               // The LCG steps together with the response beat being loaded.
               if (slot_free) begin
                  lcg_ff       <= acc_ff + (lcg_increment | W'(1));
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= mix_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;
   assign status.busy      = (state_ff != ST_IDLE);
   assign status.publish   = publish;

endmodule

`default_nettype wire

[design/lxm_l64x1024_generator.sv]
// ----------------------------------------------------------------------------
// LXM L64X1024Mix random number generator
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats carry a mode, a word index and a load value. A generate
//   beat returns one 64-bit random word on the response channel; a ring load
//   or LCG load returns nothing, and the unused mode is accepted and ignored.
//   Configuration writes (LCG increment and multiplier) take effect at once
//   and must be made only while the block is idle; the block does not check.
// Sequencing:
//   A two-entry queue sits between the request side and the sequencer, so
//   beats are taken while earlier work runs. A load is carried out while the
//   sequencer stays idle. A generate leaves the queue and passes through the
//   ring reads and writes, then the three 64-bit products that share one
//   32x32 multiplier, and is then offered on the response channel. A new
//   item leaves the queue only once the previous generate has been published.
// Reset and stalls:
//   Reset clears the pointer, LCG state and queue; unwritten ring words read
//   as zero. The response is held in an output register; while the receiver
//   stalls, the next generate waits at its final step and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module lxm_l64x1024_generator #(
   parameter int RING_DEPTH = lxm_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [lxm_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [lxm_pkg::INDEX_W-1:0]       req_word_index,
   input  wire logic [lxm_pkg::WORD_W-1:0]        req_load_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [lxm_pkg::WORD_W-1:0]        rsp_random_value,
   input  wire logic                              csr_wr_en,
   input  wire logic [lxm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lxm_pkg::WORD_W-1:0]        csr_wdata
);

   logic [lxm_pkg::WORD_W-1:0] lcg_increment_ff;
   logic [lxm_pkg::WORD_W-1:0] lcg_multiplier_ff;

   logic                       q_valid;
   lxm_pkg::item_type          q_item;
   logic                       q_pop;
   lxm_pkg::back_status_type   status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_increment_ff  <= lxm_pkg::LCG_INCREMENT_RESET;
         lcg_multiplier_ff <= lxm_pkg::LCG_MULTIPLIER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lxm_pkg::CSR_LCG_INCREMENT:  lcg_increment_ff  <= csr_wdata;
            lxm_pkg::CSR_LCG_MULTIPLIER: lcg_multiplier_ff <= csr_wdata;
            default:                     lcg_increment_ff  <= lcg_increment_ff;
         endcase
      end
   end

   lxm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_word_index (req_word_index),
      .req_load_value (req_load_value),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   lxm_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .lcg_increment    (lcg_increment_ff),
      .lcg_multiplier   (lcg_multiplier_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .status           (status)
   );

   // The back end only takes work that the queue actually holds.
   a_pop_has_item : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // Work leaves the queue only while the sequencer is idle.
   a_pop_when_idle : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !status.busy)
      else $error("queue popped while the sequencer was busy");

   // Back pressure on requests only arises with work waiting in the queue.
   a_stall_has_backlog : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("request stalled with an empty queue");

   // A new response beat only follows the publish step of a generate.
   a_rsp_from_publish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.publish))
      else $error("response appeared without a publish step");

   // No response is offered straight after reset.
   a_rsp_clear_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire
